[rtl/affine_vector_transform_4x4_unit_assert.svh]
// Assertion macros for the affine vector transform unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef AFFINE_VECTOR_TRANSFORM_4X4_UNIT_ASSERT_SVH
`define AFFINE_VECTOR_TRANSFORM_4X4_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define AVT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define AVT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define AVT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define AVT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/avt_pkg.sv]
// Shared types and constants for the affine vector transform unit.
// No dependencies; imported by the lane, merge and top-level modules.
package avt_pkg;

    localparam int ROW_W      = 64;
    localparam int COEF_SLOT  = 16;
    localparam int FIELD_W    = 32;
    localparam int FRAC_BITS  = 12;
    localparam int ONE_Q16    = 65536;
    localparam int NUM_LANES  = 4;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [2:0] {
        OP_POINT2  = 3'd0,
        OP_POINT3  = 3'd1,
        OP_VEC4    = 3'd2,
        OP_NORMAL2 = 3'd3,
        OP_NORMAL3 = 3'd4
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 3'd3;

    // which components an item produces
    typedef struct packed {
        logic defined;
        logic has_z;
        logic has_w;
    } mode_t;

    // stage load enables handed to each lane
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } lane_ctl_t;

endpackage

[rtl/avt_lane.sv]
// One dot-product lane: four signed multiplies, then an exact four-term sum.
// Depends on avt_pkg for the row layout and the lane control struct.
module avt_lane #(
    parameter int COEF_WIDTH = 16,
    parameter int VEC_WIDTH  = 32
) (
    input  logic                                   clk,
    input  logic [avt_pkg::ROW_W-1:0]              row,
    input  logic signed [VEC_WIDTH-1:0]            vec [avt_pkg::NUM_LANES],
    input  avt_pkg::lane_ctl_t                     ctl,
    output logic signed [COEF_WIDTH+VEC_WIDTH+1:0] sum
);
    import avt_pkg::*;

    localparam int PROD_W = COEF_WIDTH + VEC_WIDTH;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [COEF_WIDTH-1:0] coef      [NUM_LANES];
    logic signed [PROD_W-1:0]     prod_reg  [NUM_LANES];
    logic signed [PROD_W-1:0]     prod_next [NUM_LANES];
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [SUM_W-1:0]      sum_next;

    always_comb
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            coef[j]      = row[COEF_SLOT*j +: COEF_WIDTH];
            prod_next[j] = coef[j] * vec[j];
        end
        sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                 + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.prod_en)
        begin
            for (int j = 0; j < NUM_LANES; j++)
            begin
                prod_reg[j] <= prod_next[j];
            end
        end
        if (ctl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

[rtl/avt_merge.sv]
// Merge stage: floor shift, saturation and mode masking of the four lane sums.
// Depends on avt_pkg; holds the payload of the output register.
module avt_merge #(
    parameter int SUM_WIDTH  = 50,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic signed [SUM_WIDTH-1:0]         sums [avt_pkg::NUM_LANES],
    input  avt_pkg::mode_t                      mode,
    input  logic                                load,
    output logic [avt_pkg::FIELD_W-1:0]         comp [avt_pkg::NUM_LANES],
    output logic                                saturated
);
    import avt_pkg::*;

    localparam logic signed [SUM_WIDTH-1:0] SAT_HI =
        {{(SUM_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SAT_LO =
        {{(SUM_WIDTH-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    logic signed [SUM_WIDTH-1:0]  shifted  [NUM_LANES];
    logic signed [DATA_WIDTH-1:0] clamped  [NUM_LANES];
    logic [NUM_LANES-1:0]         produced;
    logic [NUM_LANES-1:0]         clip;
    logic [FIELD_W-1:0]           comp_next [NUM_LANES];
    logic [FIELD_W-1:0]           comp_reg  [NUM_LANES];
    logic                         sat_next;
    logic                         sat_reg;

    always_comb
    begin
        produced = {mode.defined & mode.has_w, mode.defined & mode.has_z,
                    mode.defined, mode.defined};
        for (int k = 0; k < NUM_LANES; k++)
        begin
            // arithmetic shift gives floor toward minus infinity
            shifted[k] = sums[k] >>> FRAC_BITS;
            clip[k]    = 1'b0;
            clamped[k] = shifted[k][DATA_WIDTH-1:0];
            if (shifted[k] > SAT_HI)
            begin
                clamped[k] = SAT_HI[DATA_WIDTH-1:0];
                clip[k]    = 1'b1;
            end
            else if (shifted[k] < SAT_LO)
            begin
                clamped[k] = SAT_LO[DATA_WIDTH-1:0];
                clip[k]    = 1'b1;
            end
            comp_next[k] = produced[k] ? FIELD_W'(clamped[k]) : '0;
        end
        sat_next = |(clip & produced);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                comp_reg[k] <= comp_next[k];
            end
            sat_reg <= sat_next;
        end
    end

    assign comp      = comp_reg;
    assign saturated = sat_reg;

endmodule

[rtl/affine_vector_transform_4x4_unit.sv]
// Affine 4x4 vector transform: four row lanes multiply the vector, a merge stage
// shifts, saturates and masks. An item passes through the input register, product
// register, sum register and output register in that order. Throughput: one item
// per cycle while m_tready holds, set by the four-stage pipeline with its per-stage
// ready chain. Reset clears the pipeline valids and loads the identity.
module affine_vector_transform_4x4_unit #(
    parameter int COEF_WIDTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [127:0]                   s_tdata,   // in_x, in_y, in_z, in_w
    input  logic [2:0]                     s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [127:0]                   m_tdata,   // out_x, out_y, out_z, out_w
    output logic [0:0]                     m_tuser,   // saturated
    input  logic                           cfg_we,
    input  logic [avt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [avt_pkg::ROW_W-1:0]      cfg_data
);
    `include "affine_vector_transform_4x4_unit_assert.svh"
    import avt_pkg::*;

    localparam int VEC_W = (DATA_WIDTH > 17) ? DATA_WIDTH : 18;
    localparam int SUM_W = COEF_WIDTH + VEC_W + 2;

    logic [ROW_W-1:0]          row_reg [NUM_LANES];
    logic signed [VEC_W-1:0]   vec_reg [NUM_LANES];
    logic signed [VEC_W-1:0]   vec_next [NUM_LANES];
    logic signed [DATA_WIDTH-1:0] in_c [NUM_LANES];
    mode_t                     mode_next;
    mode_t                     mode0_reg;
    mode_t                     mode1_reg;
    mode_t                     mode2_reg;
    logic                      valid0_reg;
    logic                      valid1_reg;
    logic                      valid2_reg;
    logic                      valid3_reg;
    logic                      rdy0;
    logic                      rdy1;
    logic                      rdy2;
    logic                      rdy3;
    lane_ctl_t                 lane_ctl;
    logic signed [SUM_W-1:0]   sums [NUM_LANES];
    logic [FIELD_W-1:0]        comp [NUM_LANES];
    logic                      sat;

    // ready chain: a stage loads when it is empty or its contents move on
    assign rdy3 = !valid3_reg || m_tready;
    assign rdy2 = !valid2_reg || rdy3;
    assign rdy1 = !valid1_reg || rdy2;
    assign rdy0 = !valid0_reg || rdy1;
    assign s_tready = rdy0;

    assign lane_ctl.prod_en = rdy1;
    assign lane_ctl.sum_en  = rdy2;

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            in_c[k] = s_tdata[FIELD_W*k +: DATA_WIDTH];
        end
        vec_next[0] = VEC_W'(in_c[0]);
        vec_next[1] = VEC_W'(in_c[1]);
        vec_next[2] = '0;
        vec_next[3] = '0;
        mode_next   = '{defined: 1'b1, has_z: 1'b0, has_w: 1'b0};
        case (opcode_t'(s_tuser))
            OP_POINT2:
            begin
                vec_next[3] = VEC_W'(ONE_Q16);
            end
            OP_POINT3:
            begin
                vec_next[2]     = VEC_W'(in_c[2]);
                vec_next[3]     = VEC_W'(ONE_Q16);
                mode_next.has_z = 1'b1;
            end
            OP_VEC4:
            begin
                vec_next[2]     = VEC_W'(in_c[2]);
                vec_next[3]     = VEC_W'(in_c[3]);
                mode_next.has_z = 1'b1;
                mode_next.has_w = 1'b1;
            end
            OP_NORMAL2:
            begin
                vec_next[3] = '0;
            end
            OP_NORMAL3:
            begin
                vec_next[2]     = VEC_W'(in_c[2]);
                mode_next.has_z = 1'b1;
            end
            default:
            begin
                mode_next.defined = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= 64'h0000_0000_0000_1000;
            row_reg[1] <= 64'h0000_0000_1000_0000;
            row_reg[2] <= 64'h0000_1000_0000_0000;
            row_reg[3] <= 64'h1000_0000_0000_0000;
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW0: row_reg[0] <= cfg_data;
                    REG_ROW1: row_reg[1] <= cfg_data;
                    REG_ROW2: row_reg[2] <= cfg_data;
                    REG_ROW3: row_reg[3] <= cfg_data;
                    default:  ;
                endcase
            end
            if (rdy0)
            begin
                valid0_reg <= s_tvalid;
            end
            if (rdy1)
            begin
                valid1_reg <= valid0_reg;
            end
            if (rdy2)
            begin
                valid2_reg <= valid1_reg;
            end
            if (rdy3)
            begin
                valid3_reg <= valid2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            vec_reg   <= vec_next;
            mode0_reg <= mode_next;
        end
        if (rdy1)
        begin
            mode1_reg <= mode0_reg;
        end
        if (rdy2)
        begin
            mode2_reg <= mode1_reg;
        end
    end

    for (genvar r = 0; r < NUM_LANES; r++)
    begin : g_lane
        avt_lane #(
            .COEF_WIDTH (COEF_WIDTH),
            .VEC_WIDTH  (VEC_W)
        ) u_lane (
            .clk (clk),
            .row (row_reg[r]),
            .vec (vec_reg),
            .ctl (lane_ctl),
            .sum (sums[r])
        );
    end

    avt_merge #(
        .SUM_WIDTH  (SUM_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .clk       (clk),
        .sums      (sums),
        .mode      (mode2_reg),
        .load      (rdy3),
        .comp      (comp),
        .saturated (sat)
    );

    assign m_tvalid   = valid3_reg;
    assign m_tdata    = {comp[3], comp[2], comp[1], comp[0]};
    assign m_tuser[0] = sat;

    `AVT_ASSERT_NXT(a_sum_reaches_out, clk, rst_n, valid2_reg && rdy3, m_tvalid,
                    "finished sum did not reach the output register")
    `AVT_ASSERT_NXT(a_prod_held, clk, rst_n, valid1_reg && !rdy2, valid1_reg,
                    "stalled product stage lost its transaction")
    `AVT_ASSERT_IMP(a_empty_out_ready, clk, rst_n, !m_tvalid, s_tready,
                    "input blocked while output register is empty")

endmodule
